// ----- rtl/skf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package skf_pkg;

  localparam int unsigned DATA_W        = 32;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned CFG_IDX_W     = 1;

  // Reset value of both noise registers (1.0 in the default format)
  localparam logic [DATA_W-1:0] NOISE_RESET = 32'd65536;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEASURE_NOISE = 1'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRED,
    ST_DEN,
    ST_DIV,
    ST_PREP,
    ST_MUL,
    ST_DONE
  } skf_state_e;

endpackage

`default_nettype wire

// ----- rtl/scalar_kalman_filter.sv -----
`timescale 1ns / 1ps
`default_nettype none

// One-dimensional Kalman filter on signed fixed-point samples (FRAC_BITS fraction bits).
// Input channel: measurement_i with in_valid_i / in_stall_o. Output channel: estimate_o
// with out_valid_o / out_stall_i. A transaction moves when valid is high and stall is low.
// Configuration: pulse cfg_we_i with cfg_idx_i (0 = process noise Q, 1 = measurement
// noise R) and cfg_data_i; write only while the filter is idle.
// Each measurement yields exactly one estimate. A new measurement is taken only once the
// previous one has been worked through and the filter is idle again. The work is done by
// the bit-serial restoring divider that forms the gain (one quotient bit a cycle) and
// then by two shift-add multipliers that run side by side (one gain bit a cycle).
// The finished estimate sits in an output register, so a stalled receiver holds the
// result there while the next measurement is taken and processed; the filter waits in
// its last step only if a new result is ready before the old one has been taken.
// Reset clears the estimate and the error variance to zero, sets Q and R to 1.0 in the
// default format (raw 65536) and empties the output register.
module scalar_kalman_filter
  import skf_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [DATA_W-1:0]    cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic signed [DATA_W-1:0] measurement_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic signed [DATA_W-1:0]  estimate_o
);

  localparam int unsigned GAIN_W = FRAC_BITS + 1;
  localparam int unsigned CNT_W  = $clog2(FRAC_BITS + 1);
  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << FRAC_BITS;
  localparam logic [CNT_W-1:0]  DIV_LAST = CNT_W'(FRAC_BITS - 1);
  localparam logic [CNT_W-1:0]  MUL_LAST = CNT_W'(FRAC_BITS);

  skf_state_e state_q, state_d;

  // Configuration registers
  logic [DATA_W-1:0] pnoise_q, mnoise_q;

  // Filter state
  logic signed [DATA_W-1:0] est_q;
  logic [DATA_W-1:0]        var_q;

  // Working registers for one transaction
  logic signed [DATA_W-1:0] meas_q;
  logic [DATA_W-1:0]        pred_q;
  logic [DATA_W:0]          den_q;
  logic                     dnz_q;
  logic [DATA_W:0]          rem_q;
  logic [GAIN_W-1:0]        gain_q;
  logic [GAIN_W-1:0]        omg_q;
  logic [CNT_W-1:0]         cnt_q;
  logic signed [DATA_W:0]   diff_q;
  logic signed [DATA_W+2:0] dhi_q;
  logic [DATA_W+1:0]        vhi_q;

  // Output register
  logic                     out_valid_q;
  logic signed [DATA_W-1:0] out_q;

  // Control decodes
  logic in_take;
  logic out_take;
  logic out_free;
  logic finish;

  // Datapath terms
  logic [DATA_W:0]          pred_sum;
  logic [DATA_W-1:0]        pred_sat;
  logic [DATA_W:0]          den_sum;
  logic [DATA_W+1:0]        rem_dbl;
  logic                     qbit;
  logic signed [DATA_W+2:0] dhi_add;
  logic [DATA_W+1:0]        vhi_add;
  logic signed [DATA_W+3:0] est_sum;
  logic signed [DATA_W-1:0] est_new;

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_PRED;
      end
      ST_PRED: state_d = ST_DEN;
      ST_DEN:  state_d = ST_DIV;
      ST_DIV: begin
        if (cnt_q == DIV_LAST) state_d = ST_PREP;
      end
      ST_PREP: state_d = ST_MUL;
      ST_MUL: begin
        if (cnt_q == MUL_LAST) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    in_take    = in_valid_i && (state_q == ST_IDLE);
    out_take   = out_valid_q && !out_stall_i;
    out_free   = !out_valid_q || !out_stall_i;
    finish     = (state_q == ST_DONE) && out_free;
  end

  assign out_valid_o = out_valid_q;
  assign estimate_o  = out_q;

  // ---------------------------------------------------------------------------
  // Datapath terms
  // ---------------------------------------------------------------------------
  // Predicted variance, saturating at the all-ones value
  assign pred_sum = {1'b0, var_q} + {1'b0, pnoise_q};
  assign pred_sat = pred_sum[DATA_W] ? {DATA_W{1'b1}} : pred_sum[DATA_W-1:0];

  // Gain denominator in 33 bits
  assign den_sum = {1'b0, pred_q} + {1'b0, mnoise_q};

  // Restoring division step; a zero denominator yields no quotient bits
  assign rem_dbl = {rem_q, 1'b0};
  assign qbit    = dnz_q && (rem_dbl >= {1'b0, den_q});

  // Shift-add steps, least significant multiplier bit first
  assign dhi_add = dhi_q + (gain_q[0] ? {{2{diff_q[DATA_W]}}, diff_q} : '0);
  assign vhi_add = vhi_q + (omg_q[0] ? {2'b00, pred_q} : '0);

  // Estimate update; the gain never exceeds 1.0, so the guard never fires in practice
  assign est_sum = {{4{est_q[DATA_W-1]}}, est_q} + {dhi_q[DATA_W+2], dhi_q};
  always_comb begin
    if (est_sum > (DATA_W+4)'(signed'({1'b0, {(DATA_W-1){1'b1}}}))) begin
      est_new = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (est_sum < (DATA_W+4)'(signed'({1'b1, {(DATA_W-1){1'b0}}}))) begin
      est_new = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      est_new = est_sum[DATA_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pnoise_q    <= NOISE_RESET;
      mnoise_q    <= NOISE_RESET;
      est_q       <= '0;
      var_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_PROCESS_NOISE: pnoise_q <= cfg_data_i;
          REG_MEASURE_NOISE: mnoise_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (finish) begin
        // commit filter state and present the result
        est_q       <= est_new;
        var_q       <= vhi_q[DATA_W-1:0];
        out_valid_q <= 1'b1;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Working registers (no reset needed)
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_take) meas_q <= measurement_i;
    if (finish) out_q <= est_new;

    case (state_q)
      ST_PRED: pred_q <= pred_sat;
      ST_DEN: begin
        den_q <= den_sum;
        dnz_q <= (den_sum != '0);
        cnt_q <= '0;
        // With R = 0 the quotient is exactly 1.0 (or 0 when pred is 0 too);
        // otherwise pred < den and the integer bit is zero.
        if (mnoise_q == '0) begin
          rem_q  <= '0;
          gain_q <= (pred_q != '0) ? GAIN_W'(1) : '0;
        end else begin
          rem_q  <= {1'b0, pred_q};
          gain_q <= '0;
        end
      end
      ST_DIV: begin
        rem_q  <= qbit ? (rem_dbl[DATA_W:0] - den_q) : rem_dbl[DATA_W:0];
        gain_q <= {gain_q[GAIN_W-2:0], qbit};
        cnt_q  <= cnt_q + CNT_W'(1);
      end
      ST_PREP: begin
        omg_q  <= GAIN_ONE - gain_q;
        diff_q <= {meas_q[DATA_W-1], meas_q} - {est_q[DATA_W-1], est_q};
        dhi_q  <= '0;
        vhi_q  <= '0;
        cnt_q  <= '0;
      end
      ST_MUL: begin
        gain_q <= gain_q >> 1;
        omg_q  <= omg_q >> 1;
        cnt_q  <= cnt_q + CNT_W'(1);
        if (cnt_q == MUL_LAST) begin
          // weight of the top bit is 1.0: add without shifting
          dhi_q <= dhi_add;
          vhi_q <= vhi_add;
        end else begin
          dhi_q <= dhi_add >>> 1;
          vhi_q <= vhi_add >> 1;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ----- verif/scalar_kalman_filter_tb.sv -----
`timescale 1ns / 1ps

module scalar_kalman_filter_tb
  import skf_pkg::*;
();

  localparam int unsigned FRAC        = FRAC_BITS_DEF;
  localparam logic [63:0] ONE_Q       = 64'd1 << FRAC;
  localparam int unsigned N_RANDOM    = 900;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  // Guard time after the drain, longer than one filter pass, before the verdict.
  localparam int unsigned END_GUARD   = 4 * FRAC + 16;

  typedef enum logic {
    ROW_SAMPLE,
    ROW_WRITE
  } row_kind_e;

  // One row of the directed sequence: a sample or a noise register write.
  // For a sample, value is the measurement; typed_est is used only where
  // has_typed is set, otherwise the predictor supplies the expectation.
  typedef struct packed {
    row_kind_e              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [DATA_W-1:0]      value;
    logic                   has_typed;
    logic [DATA_W-1:0]      typed_est;
  } step_row_t;

  localparam int unsigned N_DIR = 25;

  step_row_t dir_rows [N_DIR] = '{
    // Reset setting, Q = R = 1.0, zero estimate: half gain on a zero sample
    '{ROW_SAMPLE, REG_PROCESS_NOISE, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{ROW_SAMPLE, REG_PROCESS_NOISE, 32'h7FFF_FFFF, 1'b0, 32'h0},
    '{ROW_SAMPLE, REG_PROCESS_NOISE, 32'h8000_0000, 1'b0, 32'h0},
    '{ROW_SAMPLE, REG_PROCESS_NOISE, 32'h8000_0000, 1'b0, 32'h0},
    '{ROW_SAMPLE, REG_PROCESS_NOISE, 32'h7FFF_FFFF, 1'b0, 32'h0},
    '{ROW_SAMPLE, REG_PROCESS_NOISE, 32'hFFFF_FFFF, 1'b0, 32'h0},
    '{ROW_SAMPLE, REG_PROCESS_NOISE, 32'h0001_0000, 1'b0, 32'h0},
    // Both noises zero: full gain once, then zero denominator holds the estimate
    '{ROW_WRITE,  REG_PROCESS_NOISE, 32'h0000_0000, 1'b0, 32'h0},
    '{ROW_WRITE,  REG_MEASURE_NOISE, 32'h0000_0000, 1'b0, 32'h0},
    '{ROW_SAMPLE, REG_PROCESS_NOISE, 32'h1234_5678, 1'b1, 32'h1234_5678},
    '{ROW_SAMPLE, REG_PROCESS_NOISE, 32'h8000_0000, 1'b1, 32'h1234_5678},
    '{ROW_SAMPLE, REG_PROCESS_NOISE, 32'h7FFF_FFFF, 1'b1, 32'h1234_5678},
    // Both noises at the top: predicted variance saturates
    '{ROW_WRITE,  REG_PROCESS_NOISE, 32'hFFFF_FFFF, 1'b0, 32'h0},
    '{ROW_WRITE,  REG_MEASURE_NOISE, 32'hFFFF_FFFF, 1'b0, 32'h0},
    '{ROW_SAMPLE, REG_PROCESS_NOISE, 32'h8000_0000, 1'b0, 32'h0},
    '{ROW_SAMPLE, REG_PROCESS_NOISE, 32'h7FFF_FFFF, 1'b0, 32'h0},
    '{ROW_SAMPLE, REG_PROCESS_NOISE, 32'h7FFF_FFFF, 1'b0, 32'h0},
    // No process noise against huge measurement noise: the gain falls with each sample
    '{ROW_WRITE,  REG_PROCESS_NOISE, 32'h0000_0000, 1'b0, 32'h0},
    '{ROW_SAMPLE, REG_PROCESS_NOISE, 32'h8000_0000, 1'b0, 32'h0},
    '{ROW_SAMPLE, REG_PROCESS_NOISE, 32'h0000_0001, 1'b0, 32'h0},
    // Saturated prediction with zero measurement noise: estimate tracks the sample
    '{ROW_WRITE,  REG_PROCESS_NOISE, 32'hFFFF_FFFF, 1'b0, 32'h0},
    '{ROW_WRITE,  REG_MEASURE_NOISE, 32'h0000_0000, 1'b0, 32'h0},
    '{ROW_SAMPLE, REG_PROCESS_NOISE, 32'h8000_0000, 1'b1, 32'h8000_0000},
    '{ROW_SAMPLE, REG_PROCESS_NOISE, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF},
    '{ROW_SAMPLE, REG_PROCESS_NOISE, 32'h0000_0000, 1'b1, 32'h0000_0000}
  };

  // Clock, reset and every block input start at known values.
  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_idx_i     = REG_PROCESS_NOISE;
  logic [DATA_W-1:0]        cfg_data_i    = '0;
  logic                     in_valid_i    = 1'b0;
  logic signed [DATA_W-1:0] measurement_i = '0;
  logic                     out_stall_i   = 1'b0;
  logic                     in_stall_o;
  logic                     out_valid_o;
  logic signed [DATA_W-1:0] estimate_o;

  // Predictor state: noise registers, estimate and error variance.
  logic [DATA_W-1:0]        noise_q   = NOISE_RESET;
  logic [DATA_W-1:0]        noise_r   = NOISE_RESET;
  logic signed [DATA_W-1:0] est_state = '0;
  logic [DATA_W-1:0]        var_state = '0;

  logic signed [DATA_W-1:0] est_queue [$];
  int unsigned              mismatches  = 0;
  int unsigned              cycle_count = 0;

  scalar_kalman_filter #(
    .FRAC_BITS(FRAC)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .measurement_i(measurement_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .estimate_o   (estimate_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Advance the filter state by one measurement and return the new estimate.
  function automatic logic signed [DATA_W-1:0] kalman_update(
    input logic signed [DATA_W-1:0] meas
  );
    logic [63:0] pred;
    logic [63:0] den;
    logic [63:0] gain;
    longint      diff;
    longint      prod;
    longint      est;
    pred = 64'(var_state) + 64'(noise_q);
    if (pred > 64'hFFFF_FFFF) begin
      pred = 64'hFFFF_FFFF;
    end
    den  = pred + 64'(noise_r);
    gain = (den == 64'd0) ? 64'd0 : (pred << FRAC) / den;
    if (gain > ONE_Q) begin
      gain = ONE_Q;
    end
    diff = longint'(meas) - longint'(est_state);
    prod = longint'(gain) * diff;
    // Arithmetic shift rounds toward minus infinity.
    est  = longint'(est_state) + (prod >>> FRAC);
    if (est > 64'sd2147483647) begin
      est = 64'sd2147483647;
    end
    if (est < -64'sd2147483648) begin
      est = -64'sd2147483648;
    end
    est_state = est[DATA_W-1:0];
    var_state = 32'(((ONE_Q - gain) * pred) >> FRAC);
    return est_state;
  endfunction

  // Mix extremes, full-range values and small steps around the estimate.
  function automatic logic signed [DATA_W-1:0] pick_measurement();
    logic signed [DATA_W-1:0] meas;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0: meas = 32'h8000_0000;
          1: meas = 32'h7FFF_FFFF;
          2: meas = 32'h0000_0000;
          default: meas = 32'hFFFF_FFFF;
        endcase
      end
      5, 6, 7: begin
        meas = 32'(longint'(est_state) + longint'($urandom_range(0, 32'h4_0000)) - 64'sh2_0000);
      end
      default: meas = $urandom;
    endcase
    return meas;
  endfunction

  function automatic logic [DATA_W-1:0] pick_noise();
    logic [DATA_W-1:0] value;
    case ($urandom_range(0, 5))
      0: value = 32'h0000_0000;
      1: value = 32'hFFFF_FFFF;
      2: value = NOISE_RESET;
      3: value = $urandom;
      4: value = $urandom_range(0, 32'h4_0000);
      default: value = $urandom_range(1, 16);
    endcase
    return value;
  endfunction

  // Drive one measurement and hold it until the transaction moves; leave valid
  // high so a following sample can go back to back.
  task automatic send_sample(
    input logic signed [DATA_W-1:0] meas,
    input logic                     has_typed,
    input logic signed [DATA_W-1:0] typed_est
  );
    logic signed [DATA_W-1:0] predicted;
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    measurement_i <= meas;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    predicted = kalman_update(meas);
    est_queue.push_back(has_typed ? typed_est : predicted);
  endtask

  // Drop valid and scramble the idle payload; n sets how long valid stays low.
  task automatic hold_off(input int unsigned n);
    @(negedge clk_i);
    in_valid_i    <= 1'b0;
    measurement_i <= $urandom;
    repeat (n - 1) begin
      @(negedge clk_i);
    end
  endtask

  // Stop sending and wait until every expected estimate has come back.
  task automatic drain_results();
    hold_off(1);
    while (est_queue.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic write_noise(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    cfg_data_i <= $urandom;
    if (idx == REG_PROCESS_NOISE) begin
      noise_q = value;
    end else begin
      noise_r = value;
    end
  endtask

  // Receiver stall pattern: switch at random among free flow, light, heavy and
  // periodic long stalls.
  int unsigned rx_mode = 0;
  int unsigned rx_left = 0;

  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_left <= $urandom_range(20, 300);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= ($urandom_range(0, 1) == 0);
      default: out_stall_i <= ((rx_left % 64) < 24);
    endcase
  end

  // Check each accepted estimate against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (est_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected estimate %0d (0x%08h)", estimate_o, estimate_o);
        end
      end else begin
        if (estimate_o !== est_queue[0]) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("estimate mismatch: expected %0d (0x%08h) got %0d (0x%08h)",
                     est_queue[0], est_queue[0], estimate_o, estimate_o);
          end
        end
        void'(est_queue.pop_front());
      end
    end
  end

  // Bound the run; a hang ends here.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int unsigned sent;
    int unsigned phase_left;
    int unsigned burst;
    sent = 0;
    repeat (12) begin
      @(posedge clk_i);
    end
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: walk the table; write registers only once drained.
    for (int i = 0; i < N_DIR; i++) begin
      if (dir_rows[i].kind == ROW_WRITE) begin
        drain_results();
        write_noise(dir_rows[i].idx, dir_rows[i].value);
      end else begin
        send_sample(dir_rows[i].value, dir_rows[i].has_typed, dir_rows[i].typed_est);
      end
    end

    // Random part: phases of one noise setting each, samples sent in bursts.
    while (sent < N_RANDOM) begin
      drain_results();
      case ($urandom_range(0, 2))
        0: write_noise(REG_PROCESS_NOISE, pick_noise());
        1: write_noise(REG_MEASURE_NOISE, pick_noise());
        default: begin
          write_noise(REG_MEASURE_NOISE, pick_noise());
          write_noise(REG_PROCESS_NOISE, pick_noise());
        end
      endcase
      phase_left = $urandom_range(20, 120);
      while (phase_left > 0 && sent < N_RANDOM) begin
        burst = $urandom_range(1, 20);
        while (burst > 0 && phase_left > 0 && sent < N_RANDOM) begin
          send_sample(pick_measurement(), 1'b0, '0);
          sent++;
          phase_left--;
          burst--;
        end
        hold_off($urandom_range(0, 3) == 0 ? 1 : $urandom_range(1, 60));
      end
    end

    drain_results();
    repeat (END_GUARD) begin
      @(posedge clk_i);
    end
    if (mismatches == 0 && est_queue.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
